>>> hw/rtl/vgm_pkg.sv
// Shared types and constants of the command stream parser.
package vgm_pkg;

   localparam logic [7:0]  CMD_YM3812    = 8'h5A;
   localparam logic [7:0]  CMD_OPL3_PORT0 = 8'h5E;
   localparam logic [7:0]  CMD_OPL3_PORT1 = 8'h5F;
   localparam logic [7:0]  CMD_WAIT_N    = 8'h61;
   localparam logic [7:0]  CMD_WAIT_60   = 8'h62;
   localparam logic [7:0]  CMD_WAIT_50   = 8'h63;
   localparam logic [7:0]  CMD_END       = 8'h66;
   localparam logic [7:0]  CMD_DATA_BLOCK = 8'h67;
   localparam logic [31:0] VERSION_TWO_OPERANDS = 32'h0000_0160;

   localparam int SKIP_WIDTH  = 31;
   localparam int COUNT_WIDTH = 4;

   localparam logic [1:0] EVENT_SINGLE_WRITE = 2'd0;
   localparam logic [1:0] EVENT_DUAL_WRITE   = 2'd1;
   localparam logic [1:0] EVENT_WAIT         = 2'd2;
   localparam logic [1:0] EVENT_END          = 2'd3;

   localparam logic CAUSE_END_COMMAND = 1'b0;
   localparam logic CAUSE_UNKNOWN     = 1'b1;

   typedef enum logic [2:0] {
      PH_CMD,
      PH_ADDR,
      PH_DATA,
      PH_SKIP,
      PH_LEN,
      PH_HALT
   } phase_type;

   typedef enum logic [2:0] {
      CLS_WRITE,
      CLS_WAIT,
      CLS_END,
      CLS_SKIP,
      CLS_UNKNOWN
   } cmd_class_type;

   typedef struct packed {
      cmd_class_type          cls;
      logic [COUNT_WIDTH-1:0] operand_count;
   } decode_type;

   typedef struct packed {
      logic [1:0] event_kind;
      logic [8:0] reg_addr;
      logic [7:0] reg_value;
      logic       end_cause;
   } event_type;

endpackage

>>> hw/rtl/vgm_if.sv
// Handshake channels of the command stream parser.
interface vgm_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] stream_byte;
   modport source (output valid, output stream_byte, input ready);
   modport sink (input valid, input stream_byte, output ready);
endinterface

interface vgm_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] event_kind;
   logic [8:0] reg_addr;
   logic [7:0] reg_value;
   logic       end_cause;
   modport source (output valid, output event_kind, output reg_addr, output reg_value,
                   output end_cause, input ready);
   modport sink (input valid, input event_kind, input reg_addr, input reg_value,
                 input end_cause, output ready);
endinterface

interface vgm_csr_if;
   logic        valid;
   logic        ready;
   logic [31:0] format_version;
   modport source (output valid, output format_version, input ready);
   modport sink (input valid, input format_version, output ready);
endinterface

>>> hw/rtl/vgm_cmd_decode.sv
// Command byte classifier and operand size table.
module vgm_cmd_decode (
   input  logic [7:0]          cmd_byte,
   input  logic [31:0]         format_version,
   output vgm_pkg::decode_type decode
);

   always_comb begin
      decode.cls           = vgm_pkg::CLS_SKIP;
      decode.operand_count = '0;
      if (cmd_byte == vgm_pkg::CMD_YM3812 || cmd_byte == vgm_pkg::CMD_OPL3_PORT0 ||
          cmd_byte == vgm_pkg::CMD_OPL3_PORT1) begin
         decode.cls = vgm_pkg::CLS_WRITE;
      end else if (cmd_byte == vgm_pkg::CMD_WAIT_N) begin
         decode.cls           = vgm_pkg::CLS_WAIT;
         decode.operand_count = 4'd2;
      end else if (cmd_byte == vgm_pkg::CMD_WAIT_60 || cmd_byte == vgm_pkg::CMD_WAIT_50 ||
                   cmd_byte[7:4] == 4'h7) begin
         decode.cls = vgm_pkg::CLS_WAIT;
      end else if (cmd_byte == vgm_pkg::CMD_END) begin
         decode.cls = vgm_pkg::CLS_END;
      end else if (cmd_byte == vgm_pkg::CMD_DATA_BLOCK) begin
         decode.operand_count = 4'd2;
      end else if (cmd_byte[7:4] == 4'h3) begin
         decode.operand_count = 4'd1;
      end else if (cmd_byte >= 8'h40 && cmd_byte <= 8'h4E) begin
         decode.operand_count = (format_version >= vgm_pkg::VERSION_TWO_OPERANDS) ? 4'd2 : 4'd1;
      end else if (cmd_byte == 8'h4F || cmd_byte == 8'h50) begin
         decode.operand_count = 4'd1;
      end else if (cmd_byte >= 8'h51 && cmd_byte <= 8'h5F) begin
         decode.operand_count = 4'd2;
      end else if (cmd_byte == 8'h68) begin
         decode.operand_count = 4'd11;
      end else if (cmd_byte[7:4] == 4'h8) begin
         decode.operand_count = 4'd0;
      end else if (cmd_byte == 8'h90 || cmd_byte == 8'h91 || cmd_byte == 8'h95) begin
         decode.operand_count = 4'd4;
      end else if (cmd_byte == 8'h92) begin
         decode.operand_count = 4'd5;
      end else if (cmd_byte == 8'h93) begin
         decode.operand_count = 4'd10;
      end else if (cmd_byte == 8'h94) begin
         decode.operand_count = 4'd1;
      end else if (cmd_byte[7:5] == 3'b101) begin
         decode.operand_count = 4'd2;
      end else if (cmd_byte[7:5] == 3'b110) begin
         decode.operand_count = 4'd3;
      end else if (cmd_byte[7:5] == 3'b111) begin
         decode.operand_count = 4'd4;
      end else begin
         decode.cls = vgm_pkg::CLS_UNKNOWN;
      end
   end

endmodule

>>> hw/rtl/vgm_parse_engine.sv
// Parse state registers and result register.
module vgm_parse_engine (
   input  logic                clock,
   input  logic                reset,
   input  logic                step_valid,
   output logic                step_ready,
   input  logic [7:0]          step_byte,
   input  vgm_pkg::decode_type decode,
   output logic                out_valid,
   input  logic                out_ready,
   output vgm_pkg::event_type  out_event
);

   vgm_pkg::phase_type              phase_ff, phase_in;
   logic [7:0]                      cmd_ff, cmd_in;
   logic [vgm_pkg::SKIP_WIDTH-1:0]  skip_ff, skip_in;
   logic [8:0]                      addr_ff, addr_in;
   logic [vgm_pkg::SKIP_WIDTH-1:0]  blen_ff, blen_in;
   logic [1:0]                      lcount_ff, lcount_in;
   logic                            out_valid_ff;
   vgm_pkg::event_type              event_ff;
   logic                            fire;
   vgm_pkg::event_type              event_in;
   logic [vgm_pkg::SKIP_WIDTH-1:0]  skip_dec;
   logic [vgm_pkg::SKIP_WIDTH-1:0]  blen_merged;
   logic                            step;

   assign step_ready = !out_valid_ff || out_ready;
   assign step       = step_valid && step_ready;
   assign skip_dec   = skip_ff - {{(vgm_pkg::SKIP_WIDTH-1){1'b0}}, 1'b1};

   always_comb begin
      case (lcount_ff)
         2'd0:    blen_merged = blen_ff | {23'd0, step_byte};
         2'd1:    blen_merged = blen_ff | {15'd0, step_byte, 8'd0};
         2'd2:    blen_merged = blen_ff | {7'd0, step_byte, 16'd0};
         default: blen_merged = blen_ff | {step_byte[6:0], 24'd0};
      endcase
   end

   always_comb begin
      phase_in  = phase_ff;
      cmd_in    = cmd_ff;
      skip_in   = skip_ff;
      addr_in   = addr_ff;
      blen_in   = blen_ff;
      lcount_in = lcount_ff;
      fire      = 1'b0;
      event_in  = '0;
      case (phase_ff)
         vgm_pkg::PH_CMD: begin
            cmd_in = step_byte;
            case (decode.cls)
               vgm_pkg::CLS_WRITE: begin
                  phase_in = vgm_pkg::PH_ADDR;
               end
               vgm_pkg::CLS_END: begin
                  phase_in           = vgm_pkg::PH_HALT;
                  fire               = 1'b1;
                  event_in.event_kind = vgm_pkg::EVENT_END;
                  event_in.end_cause  = vgm_pkg::CAUSE_END_COMMAND;
               end
               vgm_pkg::CLS_UNKNOWN: begin
                  phase_in           = vgm_pkg::PH_HALT;
                  fire               = 1'b1;
                  event_in.event_kind = vgm_pkg::EVENT_END;
                  event_in.end_cause  = vgm_pkg::CAUSE_UNKNOWN;
               end
               default: begin
                  if (decode.cls == vgm_pkg::CLS_WAIT) begin
                     fire               = 1'b1;
                     event_in.event_kind = vgm_pkg::EVENT_WAIT;
                  end
                  skip_in  = {{(vgm_pkg::SKIP_WIDTH-vgm_pkg::COUNT_WIDTH){1'b0}},
                              decode.operand_count};
                  phase_in = (decode.operand_count != '0) ? vgm_pkg::PH_SKIP : vgm_pkg::PH_CMD;
               end
            endcase
         end
         vgm_pkg::PH_ADDR: begin
            addr_in  = {cmd_ff == vgm_pkg::CMD_OPL3_PORT1, step_byte};
            phase_in = vgm_pkg::PH_DATA;
         end
         vgm_pkg::PH_DATA: begin
            phase_in            = vgm_pkg::PH_CMD;
            fire                = 1'b1;
            event_in.event_kind = (cmd_ff == vgm_pkg::CMD_YM3812) ?
                                  vgm_pkg::EVENT_SINGLE_WRITE : vgm_pkg::EVENT_DUAL_WRITE;
            event_in.reg_addr   = addr_ff;
            event_in.reg_value  = step_byte;
         end
         vgm_pkg::PH_SKIP: begin
            skip_in = skip_dec;
            if (skip_dec == '0) begin
               if (cmd_ff == vgm_pkg::CMD_DATA_BLOCK) begin
                  phase_in  = vgm_pkg::PH_LEN;
                  blen_in   = '0;
                  lcount_in = '0;
               end else begin
                  phase_in = vgm_pkg::PH_CMD;
               end
            end
         end
         vgm_pkg::PH_LEN: begin
            blen_in = blen_merged;
            if (lcount_ff == 2'd3) begin
               lcount_in = '0;
               cmd_in    = '0;
               skip_in   = blen_merged;
               phase_in  = (blen_merged != '0) ? vgm_pkg::PH_SKIP : vgm_pkg::PH_CMD;
            end else begin
               lcount_in = lcount_ff + 2'd1;
            end
         end
         vgm_pkg::PH_HALT: begin
            phase_in = vgm_pkg::PH_HALT;
         end
         default: begin
            phase_in = vgm_pkg::PH_HALT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= vgm_pkg::PH_CMD;
         cmd_ff    <= '0;
         skip_ff   <= '0;
         addr_ff   <= '0;
         blen_ff   <= '0;
         lcount_ff <= '0;
      end else if (step) begin
         phase_ff  <= phase_in;
         cmd_ff    <= cmd_in;
         skip_ff   <= skip_in;
         addr_ff   <= addr_in;
         blen_ff   <= blen_in;
         lcount_ff <= lcount_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (step) begin
         out_valid_ff <= fire;
      end else if (out_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step && fire) begin
         event_ff <= event_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_event = event_ff;

endmodule

>>> hw/rtl/vgm_command_stream_parser.sv
// Top level of the byte-serial command stream parser.
//
//   port   dir   carries                                     moves on
//   req    in    stream_byte                                 valid && ready
//   rsp    out   event_kind, reg_addr, reg_value, end_cause  valid && ready
//   csr    in    format_version                              valid && ready
//
// One byte per cycle sustained while rsp takes events; a byte's event reaches rsp
// through the input register, then the parse step into the result register.
// The single parse step (phase update, 31-bit skip decrement) sets the rate.
// Reset is synchronous; the parser then expects a command byte, version is 0x171.
// A stalled rsp holds its event; req keeps flowing while the result register can drain.
module vgm_command_stream_parser (
   input  logic            clock,
   input  logic            reset,
   vgm_req_if.sink         req,
   vgm_rsp_if.source       rsp,
   vgm_csr_if.sink         csr
);

   logic                 in_full_ff;
   logic [7:0]           in_byte_ff;
   logic [31:0]          version_ff;
   logic                 step_ready;
   vgm_pkg::decode_type  decode;
   vgm_pkg::event_type   out_event;

   assign req.ready = !in_full_ff || step_ready;
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_full_ff <= 1'b0;
      end else if (req.ready) begin
         in_full_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_byte_ff <= req.stream_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         version_ff <= 32'h0000_0171;
      end else if (csr.valid) begin
         version_ff <= csr.format_version;
      end
   end

   vgm_cmd_decode u_decode (
      .cmd_byte       (in_byte_ff),
      .format_version (version_ff),
      .decode         (decode)
   );

   vgm_parse_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .step_valid (in_full_ff),
      .step_ready (step_ready),
      .step_byte  (in_byte_ff),
      .decode     (decode),
      .out_valid  (rsp.valid),
      .out_ready  (rsp.ready),
      .out_event  (out_event)
   );

   assign rsp.event_kind = out_event.event_kind;
   assign rsp.reg_addr   = out_event.reg_addr;
   assign rsp.reg_value  = out_event.reg_value;
   assign rsp.end_cause  = out_event.end_cause;

endmodule

>>> hw/rtl/vgm_checker.sv
// Port-level checks of the command stream parser and their binding.
module vgm_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] event_kind,
   input logic [8:0] reg_addr,
   input logic [7:0] reg_value,
   input logic       end_cause
);

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(event_kind) && $stable(reg_addr)
         && $stable(reg_value) && $stable(end_cause))
      else $error("stalled result changed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && event_kind == vgm_pkg::EVENT_END |=> !rsp_valid)
      else $error("result after end event");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (event_kind == vgm_pkg::EVENT_WAIT || event_kind == vgm_pkg::EVENT_END)
         |-> reg_addr == '0 && reg_value == '0)
      else $error("wait or end event carries register data");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && event_kind != vgm_pkg::EVENT_END |-> end_cause == 1'b0)
      else $error("end cause set on non-end event");

endmodule

bind vgm_command_stream_parser vgm_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp.valid),
   .rsp_ready  (rsp.ready),
   .event_kind (rsp.event_kind),
   .reg_addr   (rsp.reg_addr),
   .reg_value  (rsp.reg_value),
   .end_cause  (rsp.end_cause)
);

>>> tb/sv/vgm_event_checker.sv
// Event checker of the command stream parser: predicts each event and compares it.
`timescale 1ns / 100ps

module vgm_event_checker (
   input  logic clock,
   input  logic reset,
   vgm_req_if   req,
   vgm_rsp_if   rsp,
   vgm_csr_if   csr,
   output int   failures,
   output int   outstanding
);

   localparam logic [31:0] VERSION_AT_RESET = 32'h0000_0171;
   localparam logic [7:0]  SHORT_WAIT_FIRST = 8'h70;
   localparam logic [7:0]  SHORT_WAIT_LAST  = 8'h7F;
   localparam logic [7:0]  VERSIONED_FIRST  = 8'h40;
   localparam logic [7:0]  VERSIONED_LAST   = 8'h4E;
   localparam int          UNSIZED          = -1;

   vgm_pkg::phase_type   ph;
   logic [7:0]           cmd_held;
   logic [30:0]          skip_left;
   logic [8:0]           addr_held;
   logic [30:0]          blk_len;
   logic [1:0]           len_bytes;
   logic [31:0]          version;
   vgm_pkg::event_type   pending_events[$];

   // operand size table of the generic commands
   function automatic int operand_bytes(input logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h3F) return 1;
      if (c >= VERSIONED_FIRST && c <= VERSIONED_LAST)
         return (version >= vgm_pkg::VERSION_TWO_OPERANDS) ? 2 : 1;
      if (c == 8'h4F || c == 8'h50) return 1;
      if (c >= 8'h51 && c <= 8'h5F) return 2;
      if (c == 8'h68) return 11;
      if (c >= 8'h70 && c <= 8'h8F) return 0;
      if (c == 8'h90 || c == 8'h91 || c == 8'h95) return 4;
      if (c == 8'h92) return 5;
      if (c == 8'h93) return 10;
      if (c == 8'h94) return 1;
      if (c >= 8'hA0 && c <= 8'hBF) return 2;
      if (c >= 8'hC0 && c <= 8'hDF) return 3;
      if (c >= 8'hE0) return 4;
      return UNSIZED;
   endfunction

   function automatic void begin_skip(input logic [30:0] count);
      skip_left = count;
      ph = (count != '0) ? vgm_pkg::PH_SKIP : vgm_pkg::PH_CMD;
   endfunction

   function automatic bit parse_byte(input logic [7:0] b, output vgm_pkg::event_type ev);
      bit made;
      int n;
      made = 1'b0;
      ev = '0;
      case (ph)
         vgm_pkg::PH_CMD: begin
            cmd_held = b;
            if (b == vgm_pkg::CMD_YM3812 || b == vgm_pkg::CMD_OPL3_PORT0
                || b == vgm_pkg::CMD_OPL3_PORT1) begin
               ph = vgm_pkg::PH_ADDR;
            end else if (b == vgm_pkg::CMD_WAIT_N || b == vgm_pkg::CMD_WAIT_60
                         || b == vgm_pkg::CMD_WAIT_50
                         || (b >= SHORT_WAIT_FIRST && b <= SHORT_WAIT_LAST)) begin
               if (b == vgm_pkg::CMD_WAIT_N)
                  begin_skip(31'd2);
               ev.event_kind = vgm_pkg::EVENT_WAIT;
               made = 1'b1;
            end else if (b == vgm_pkg::CMD_END) begin
               ph = vgm_pkg::PH_HALT;
               ev.event_kind = vgm_pkg::EVENT_END;
               ev.end_cause = vgm_pkg::CAUSE_END_COMMAND;
               made = 1'b1;
            end else if (b == vgm_pkg::CMD_DATA_BLOCK) begin
               begin_skip(31'd2);
            end else begin
               n = operand_bytes(b);
               if (n == UNSIZED) begin
                  ph = vgm_pkg::PH_HALT;
                  ev.event_kind = vgm_pkg::EVENT_END;
                  ev.end_cause = vgm_pkg::CAUSE_UNKNOWN;
                  made = 1'b1;
               end else begin
                  begin_skip(31'(n));
               end
            end
         end
         vgm_pkg::PH_ADDR: begin
            addr_held = {cmd_held == vgm_pkg::CMD_OPL3_PORT1, b};
            ph = vgm_pkg::PH_DATA;
         end
         vgm_pkg::PH_DATA: begin
            ph = vgm_pkg::PH_CMD;
            ev.event_kind = (cmd_held == vgm_pkg::CMD_YM3812) ?
                            vgm_pkg::EVENT_SINGLE_WRITE : vgm_pkg::EVENT_DUAL_WRITE;
            ev.reg_addr = addr_held;
            ev.reg_value = b;
            made = 1'b1;
         end
         vgm_pkg::PH_SKIP: begin
            if (skip_left != '0)
               skip_left = skip_left - 31'd1;
            if (skip_left == '0) begin
               if (cmd_held == vgm_pkg::CMD_DATA_BLOCK) begin
                  ph = vgm_pkg::PH_LEN;
                  blk_len = '0;
                  len_bytes = '0;
               end else begin
                  ph = vgm_pkg::PH_CMD;
               end
            end
         end
         vgm_pkg::PH_LEN: begin
            // the top bit of the last length byte falls off the 31-bit length
            blk_len = blk_len | (31'(b) << (8 * len_bytes));
            if (len_bytes == 2'd3) begin
               len_bytes = '0;
               cmd_held = '0;
               begin_skip(blk_len);
            end else begin
               len_bytes = len_bytes + 2'd1;
            end
         end
         default: ph = vgm_pkg::PH_HALT;
      endcase
      return made;
   endfunction

   task automatic compare_field(input string name, input int unsigned want,
                                input int unsigned seen);
      if (want != seen) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, seen);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      vgm_pkg::event_type ev;
      if (reset) begin
         ph = vgm_pkg::PH_CMD;
         cmd_held = '0;
         skip_left = '0;
         addr_held = '0;
         blk_len = '0;
         len_bytes = '0;
         version = VERSION_AT_RESET;
         pending_events.delete();
      end else begin
         if (csr.valid && csr.ready)
            version = csr.format_version;
         if (req.valid && req.ready) begin
            if (parse_byte(req.stream_byte, ev))
               pending_events.insert(pending_events.size(), ev);
         end
         if (rsp.valid && rsp.ready) begin
            if (pending_events.size() == 0) begin
               $error("event_kind 0x%0h reg_addr 0x%0h arrived with none expected",
                      rsp.event_kind, rsp.reg_addr);
               failures++;
            end else begin
               ev = pending_events.pop_front();
               compare_field("event_kind", ev.event_kind, rsp.event_kind);
               compare_field("reg_addr", ev.reg_addr, rsp.reg_addr);
               compare_field("reg_value", ev.reg_value, rsp.reg_value);
               compare_field("end_cause", ev.end_cause, rsp.end_cause);
            end
         end
      end
      outstanding = pending_events.size();
   end

endmodule

>>> tb/sv/tb.sv
// Top of the parser testbench: clock, reset, byte stream stimulus and verdict.
`timescale 1ns / 100ps

module tb;

   localparam int          HALF_PERIOD     = 6;
   localparam int          RESET_CYCLES    = 6;
   localparam int          CYCLE_LIMIT     = 250000;
   localparam int          DRAIN_CYCLES    = 6;
   localparam int          HOLD_CYCLES     = 400;
   localparam int          PRESSURE_WAITS  = 40;
   localparam int          PHASE_BYTES     = 185;
   localparam int          TRAILING_BYTES  = 12;
   localparam logic [7:0]  SHORT_WAIT_FIRST = 8'h70;
   localparam logic [7:0]  SHORT_WAIT_LAST  = 8'h7F;
   localparam logic [7:0]  NOP_LAST         = 8'h8F;

   logic        clock;
   logic        reset;
   int          failures;
   int          outstanding;
   int          bytes_sent = 0;
   int          cycles = 0;
   bit          idle_allowed = 1'b1;
   bit          send_gaps = 1'b1;
   bit          hold_rsp = 1'b0;
   logic [31:0] version_now = 32'h0000_0171;

   vgm_req_if req_ch ();
   vgm_rsp_if rsp_ch ();
   vgm_csr_if csr_ch ();

   vgm_command_stream_parser DUT (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   vgm_event_checker events_watch (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr         (csr_ch),
      .failures    (failures),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #HALF_PERIOD clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end
   end

   // event receiver: random stalls, calm stretches, one long hold-off on request
   initial begin
      int burst;
      int span;
      bit calm;
      span = 0;
      calm = 1'b0;
      rsp_ch.ready = 1'b1;
      forever begin
         @(negedge clock);
         span++;
         if (span % 64 == 0)
            calm = ($urandom_range(0, 2) == 0);
         if (hold_rsp) begin
            rsp_ch.ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_ch.ready = 1'b1;
            hold_rsp = 1'b0;
         end else if (idle_allowed && !calm && $urandom_range(0, 7) == 0) begin
            rsp_ch.ready = 1'b0;
            burst = $urandom_range(1, 13);
            repeat (burst) @(negedge clock);
            rsp_ch.ready = 1'b1;
         end
      end
   end

   task automatic send_byte(input logic [7:0] b);
      int gap;
      if (idle_allowed && send_gaps && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 13);
         repeat (gap) @(negedge clock);
      end
      req_ch.stream_byte = b;
      req_ch.valid = 1'b1;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
      req_ch.valid = 1'b0;
      bytes_sent++;
   endtask

   task automatic send_random(input int count);
      repeat (count) send_byte(8'($urandom_range(0, 255)));
   endtask

   task automatic settle();
      while (outstanding != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_version(input logic [31:0] v);
      csr_ch.format_version = v;
      csr_ch.valid = 1'b1;
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
      csr_ch.valid = 1'b0;
      version_now = v;
   endtask

   // generic command with its operand count
   task automatic pick_generic(output logic [7:0] c, output int n);
      case ($urandom_range(0, 13))
         0:        begin c = 8'h30 + 8'($urandom_range(0, 15)); n = 1; end
         1, 12, 13: begin
            c = 8'h40 + 8'($urandom_range(0, 14));
            n = (version_now >= vgm_pkg::VERSION_TWO_OPERANDS) ? 2 : 1;
         end
         2:        begin c = $urandom_range(0, 1) ? 8'h4F : 8'h50; n = 1; end
         3:        begin c = 8'h51 + 8'($urandom_range(0, 8)); n = 2; end
         4:        begin c = 8'h5B + 8'($urandom_range(0, 2)); n = 2; end
         5:        begin c = 8'h68; n = 11; end
         6:        begin c = 8'h80 + 8'($urandom_range(0, 15)); n = 0; end
         7: begin
            case ($urandom_range(0, 2))
               0:       c = 8'h90;
               1:       c = 8'h91;
               default: c = 8'h95;
            endcase
            n = 4;
         end
         8: begin
            case ($urandom_range(0, 2))
               0:       begin c = 8'h92; n = 5; end
               1:       begin c = 8'h93; n = 10; end
               default: begin c = 8'h94; n = 1; end
            endcase
         end
         9:        begin c = 8'hA0 + 8'($urandom_range(0, 31)); n = 2; end
         10:       begin c = 8'hC0 + 8'($urandom_range(0, 31)); n = 3; end
         default:  begin c = 8'hE0 + 8'($urandom_range(0, 31)); n = 4; end
      endcase
   endtask

   function automatic logic [7:0] unknown_command();
      case ($urandom_range(0, 4))
         0:       return 8'($urandom_range(0, 8'h2F));
         1:       return 8'h60;
         2:       return 8'h64 + 8'($urandom_range(0, 1));
         3:       return 8'h69 + 8'($urandom_range(0, 6));
         default: return 8'h96 + 8'($urandom_range(0, 9));
      endcase
   endfunction

   task automatic send_command();
      int pick;
      int n;
      int blk;
      logic [7:0] c;
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 31) == 0)
         send_gaps = $urandom_range(0, 1);
      if (pick < 30) begin
         case ($urandom_range(0, 2))
            0:       send_byte(vgm_pkg::CMD_YM3812);
            1:       send_byte(vgm_pkg::CMD_OPL3_PORT0);
            default: send_byte(vgm_pkg::CMD_OPL3_PORT1);
         endcase
         send_random(2);
      end else if (pick < 45) begin
         case ($urandom_range(0, 3))
            0: begin
               send_byte(vgm_pkg::CMD_WAIT_N);
               send_random(2);
            end
            1:       send_byte(vgm_pkg::CMD_WAIT_60);
            2:       send_byte(vgm_pkg::CMD_WAIT_50);
            default: send_byte(SHORT_WAIT_FIRST + 8'($urandom_range(0, 15)));
         endcase
      end else if (pick < 88) begin
         pick_generic(c, n);
         send_byte(c);
         send_random(n);
      end else begin
         blk = $urandom_range(0, 24);
         send_byte(vgm_pkg::CMD_DATA_BLOCK);
         send_random(2);
         send_byte(8'(blk));
         send_byte(8'h00);
         send_byte(8'h00);
         send_byte($urandom_range(0, 1) ? 8'h80 : 8'h00);
         send_random(blk);
      end
   endtask

   task automatic run_commands(input int span);
      int target;
      target = bytes_sent + span;
      while (bytes_sent < target) send_command();
   endtask

   initial begin
      logic [7:0]  opening[$];
      logic [31:0] version_plan[5];
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.stream_byte = '0;
      csr_ch.valid = 1'b0;
      csr_ch.format_version = '0;
      opening = '{vgm_pkg::CMD_YM3812, 8'h00, 8'hFF,
                  vgm_pkg::CMD_OPL3_PORT0, 8'hFF, 8'h00,
                  vgm_pkg::CMD_OPL3_PORT1, 8'h80, 8'h7F,
                  vgm_pkg::CMD_WAIT_N, 8'hFF, 8'h00,
                  vgm_pkg::CMD_WAIT_60, vgm_pkg::CMD_WAIT_50, SHORT_WAIT_FIRST,
                  SHORT_WAIT_LAST, NOP_LAST,
                  vgm_pkg::CMD_DATA_BLOCK, vgm_pkg::CMD_END, 8'h00, 8'h00, 8'h00, 8'h00,
                  8'h80};
      version_plan = '{vgm_pkg::VERSION_TWO_OPERANDS, vgm_pkg::VERSION_TWO_OPERANDS - 32'd1,
                       32'h0000_0000, 32'hFFFF_FFFF, $urandom()};
      repeat (RESET_CYCLES) @(negedge clock);
      reset = 1'b0;

      foreach (opening[i]) send_byte(opening[i]);
      run_commands(PHASE_BYTES);

      foreach (version_plan[i]) begin
         settle();
         write_version(version_plan[i]);
         if (i == 1) begin
            // stall the receiver and keep offering waits until the input backs up
            hold_rsp = 1'b1;
            repeat (PRESSURE_WAITS) send_byte(SHORT_WAIT_FIRST + 8'($urandom_range(0, 15)));
         end
         if (i == 4) begin
            idle_allowed = 1'b0;
            send_gaps = 1'b0;
         end
         run_commands(PHASE_BYTES);
      end

      // halt the parser, then feed bytes it must drop
      if ($urandom_range(0, 1))
         send_byte(vgm_pkg::CMD_END);
      else
         send_byte(unknown_command());
      send_random(TRAILING_BYTES);
      settle();

      if (failures == 0 && outstanding == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

endmodule

>>> files.f
hw/rtl/vgm_pkg.sv
hw/rtl/vgm_if.sv
hw/rtl/vgm_cmd_decode.sv
hw/rtl/vgm_parse_engine.sv
hw/rtl/vgm_command_stream_parser.sv
hw/rtl/vgm_checker.sv
tb/sv/vgm_event_checker.sv
tb/sv/tb.sv
